@@ design/esd_pkg.sv @@
// package for the edge selective debouncer: widths, codes and shared types
`timescale 1ns / 1ps
package esd_pkg;

  // width of the time counter, differences wrap at this width
  localparam int TIME_BITS = 32;
  // hold time register width
  localparam int HOLD_BITS = 32;
  // compare width covering both elapsed time and hold time
  localparam int CMP_BITS  = (TIME_BITS > HOLD_BITS) ? TIME_BITS : HOLD_BITS;
  // width of the now_ms field on the port
  localparam int NOW_BITS  = 32;

  // stream word widths, padded to whole bytes
  localparam int IN_FIELD_BITS  = 1 + NOW_BITS;
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS  = 8;

  // configuration port
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 32;
  localparam int MODE_BITS     = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_EDGE_MODE = 1'b0,
    REG_HOLD_TIME = 1'b1
  } cfg_reg_e;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_BOTH = 2'd0,
    MODE_RISE = 2'd1,
    MODE_FALL = 2'd2
  } edge_mode_e;

  // live configuration
  typedef struct packed {
    logic [MODE_BITS-1:0] edge_mode;
    logic [HOLD_BITS-1:0] hold_time;
  } cfg_t;

  // debouncer state
  typedef struct packed {
    logic                 first_pending;
    logic                 stable_level;
    logic                 last_raw;
    logic [TIME_BITS-1:0] change_time;
  } state_t;

endpackage

@@ design/edge_selective_debouncer_core.sv @@
// top level of the edge selective debouncer
`timescale 1ns / 1ps
// Time based debouncer for one binary input. Each input word carries a raw
// sample and the current millisecond time; each yields exactly one output word
// with the debounced level. The first word after reset adopts its sample. After
// that a debounced change waits until the raw sample has been steady for at
// least hold_time ms, for the edges chosen by edge_mode (0 both, 1 rising,
// 2 or 3 falling); other edges pass at once. A word goes through the input
// register, then the result register, with a single pass of compare and subtract
// logic in between; one word is taken every cycle unless the output stalls.
// The user must write configuration while the block is idle; it has no check.
module edge_selective_debouncer_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [esd_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [esd_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [esd_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,  // raw_sample, now_ms, zero pad
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [esd_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata   // clean_level, zero pad
);
  import esd_pkg::*;

  cfg_t                cfg;
  state_t              state_q, state_d;
  logic                in_vld_q;
  logic                raw_q;
  logic [NOW_BITS-1:0] now_q;
  logic                out_vld_q;
  logic                clean_q;
  logic                advance;
  logic                in_take;

  esd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  esd_step u_step (
    .state_i (state_q),
    .cfg_i   (cfg),
    .raw_i   (raw_q),
    .now_i   (now_q),
    .state_o (state_d)
  );

  // pipeline flow: the result register frees when empty or taken
  assign advance       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      raw_q <= s_axis_tdata[0];
      now_q <= s_axis_tdata[NOW_BITS:1];
    end
  end

  // debouncer state, moves when a word passes to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.first_pending <= 1'b1;
      state_q.stable_level  <= 1'b0;
      state_q.last_raw      <= 1'b0;
      state_q.change_time   <= '0;
    end else if (in_vld_q && advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q && advance) begin
      clean_q <= state_d.stable_level;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_DATA_BITS-1){1'b0}}, clean_q};

endmodule

@@ design/esd_cfg_regs.sv @@
// configuration register file of the edge selective debouncer
`timescale 1ns / 1ps
module esd_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [esd_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [esd_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  output esd_pkg::cfg_t                      cfg_o
);
  import esd_pkg::*;

  logic [MODE_BITS-1:0] edge_mode_q, edge_mode_d;
  logic [HOLD_BITS-1:0] hold_time_q, hold_time_d;

  // register decode
  always_comb begin
    edge_mode_d = edge_mode_q;
    hold_time_d = hold_time_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_EDGE_MODE: edge_mode_d = cfg_data_i[MODE_BITS-1:0];
        REG_HOLD_TIME: hold_time_d = cfg_data_i[HOLD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_mode_q <= MODE_BOTH;
      hold_time_q <= '0;
    end else begin
      edge_mode_q <= edge_mode_d;
      hold_time_q <= hold_time_d;
    end
  end

  assign cfg_o.edge_mode = edge_mode_q;
  assign cfg_o.hold_time = hold_time_q;

endmodule

@@ design/esd_step.sv @@
// next state logic of the debouncer for one sample
`timescale 1ns / 1ps
module esd_step (
  input  esd_pkg::state_t                 state_i,
  input  esd_pkg::cfg_t                   cfg_i,
  input  logic                            raw_i,
  input  logic [esd_pkg::NOW_BITS-1:0]    now_i,
  output esd_pkg::state_t                 state_o
);
  import esd_pkg::*;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] change_eff;
  logic [TIME_BITS-1:0] elapsed;
  logic                 steady_ok;
  logic                 exempt;

  // time since the last raw change, modulo the counter width
  assign now_t      = TIME_BITS'(now_i);
  assign change_eff = (raw_i != state_i.last_raw) ? now_t : state_i.change_time;
  assign elapsed    = now_t - change_eff;
  assign steady_ok  = CMP_BITS'(elapsed) >= CMP_BITS'(cfg_i.hold_time);

  // edges that pass without waiting; the unused mode code acts as falling only
  always_comb begin
    case (cfg_i.edge_mode)
      MODE_BOTH: exempt = 1'b0;
      MODE_RISE: exempt = !raw_i;
      default:   exempt = raw_i;
    endcase
  end

  // update
  always_comb begin
    state_o = state_i;
    if (state_i.first_pending) begin
      state_o.first_pending = 1'b0;
      state_o.stable_level  = raw_i;
      state_o.last_raw      = raw_i;
      state_o.change_time   = now_t;
    end else begin
      state_o.change_time = change_eff;
      state_o.last_raw    = raw_i;
      if ((raw_i != state_i.stable_level) && (exempt || steady_ok)) begin
        state_o.stable_level = raw_i;
      end
    end
  end

endmodule

@@ bench/esd_level_checker.sv @@
// checker for the edge selective debouncer: predicts each clean level and compares
`timescale 1ns / 1ps
module esd_level_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [esd_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [esd_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                              s_tvalid_i,
  input  logic                              s_tready_i,
  input  logic [esd_pkg::IN_DATA_BITS-1:0]  s_tdata_i,   // raw_sample, now_ms, zero pad
  input  logic                              m_tvalid_i,
  input  logic                              m_tready_i,
  input  logic [esd_pkg::OUT_DATA_BITS-1:0] m_tdata_i,   // clean_level, zero pad
  output int                                outstanding_o,
  output int                                checked_o,
  output int                                fail_count_o
);
  import esd_pkg::*;

  // own copy of the debouncer state and the live settings
  logic                 first_word_pending;
  logic                 held_level;
  logic                 prev_raw;
  logic [TIME_BITS-1:0] last_edge_ms;
  logic [MODE_BITS-1:0] cur_mode;
  logic [HOLD_BITS-1:0] cur_hold;

  logic                 clean_level_q[$];
  logic                 expected_level;
  int                   n_fail;
  int                   n_checked;

  // advance the state by one word and return the debounced level
  function automatic logic next_clean_level(input logic raw,
                                            input logic [NOW_BITS-1:0] now_ms);
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] elapsed;
    logic                 exempt;
    now_t = now_ms[TIME_BITS-1:0];
    if (first_word_pending) begin
      // first word after reset is taken as it is
      first_word_pending = 1'b0;
      held_level         = raw;
      prev_raw           = raw;
      last_edge_ms       = now_t;
    end else begin
      // a raw change restarts the steady time
      if (raw != prev_raw) begin
        last_edge_ms = now_t;
      end
      elapsed = now_t - last_edge_ms;
      if (raw != held_level) begin
        case (cur_mode)
          MODE_BOTH: exempt = 1'b0;
          MODE_RISE: exempt = !raw;
          default:   exempt = raw;
        endcase
        if (exempt || (CMP_BITS'(elapsed) >= CMP_BITS'(cur_hold))) begin
          held_level = raw;
        end
      end
      prev_raw = raw;
    end
    return held_level;
  endfunction

  // watch the channels, predict on input words, compare on output words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_word_pending = 1'b1;
      held_level         = 1'b0;
      prev_raw           = 1'b0;
      last_edge_ms       = '0;
      cur_mode           = MODE_BOTH;
      cur_hold           = '0;
      clean_level_q.delete();
      n_fail             = 0;
      n_checked          = 0;
      outstanding_o     <= 0;
      checked_o         <= 0;
      fail_count_o      <= 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_EDGE_MODE) begin
          cur_mode = cfg_data_i[MODE_BITS-1:0];
        end else if (cfg_idx_i == REG_HOLD_TIME) begin
          cur_hold = cfg_data_i[HOLD_BITS-1:0];
        end
      end
      // output word against the oldest expectation
      if (m_tvalid_i && m_tready_i) begin
        if (clean_level_q.size() == 0) begin
          $error("clean_level: word with no expectation, expected none, actual %0b",
                 m_tdata_i[0]);
          n_fail++;
        end else begin
          expected_level = clean_level_q.pop_front();
          n_checked++;
          if (expected_level !== m_tdata_i[0]) begin
            $error("clean_level: expected %0b, actual %0b", expected_level, m_tdata_i[0]);
            n_fail++;
          end
        end
      end
      // input word gives one expected level
      if (s_tvalid_i && s_tready_i) begin
        clean_level_q.push_back(next_clean_level(s_tdata_i[0], s_tdata_i[NOW_BITS:1]));
      end
      outstanding_o <= clean_level_q.size();
      checked_o     <= n_checked;
      fail_count_o  <= n_fail;
    end
  end

endmodule

@@ bench/edge_selective_debouncer_core_tb.sv @@
// testbench top for the edge selective debouncer: stimulus, idling and verdict
`timescale 1ns / 1ps
module edge_selective_debouncer_core_tb;
  import esd_pkg::*;

  localparam int               CYCLE_LIMIT = 400000;
  localparam int               STALL_LEN   = 300;
  localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    PH_FREE,
    PH_TX_IDLE,
    PH_RX_STALL,
    PH_BOTH_IDLE,
    PH_PRESSURE
  } idle_phase_e;

  logic                     clk_i      = 1'b0;
  logic                     rst_ni     = 1'b0;
  logic                     cfg_we     = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx    = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data   = '0;
  logic                     s_tvalid   = 1'b0;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata    = '0;
  logic                     m_tvalid;
  logic                     m_tready   = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;

  int                       outstanding;
  int                       n_checked;
  int                       n_fail;
  int                       n_sent     = 0;
  int                       n_cycles   = 0;
  int                       tx_idle_pct = 0;
  int                       rx_stall_pct = 0;
  idle_phase_e              cur_phase  = PH_FREE;
  logic                     stretch_done = 1'b0;

  edge_selective_debouncer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  esd_level_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .outstanding_o (outstanding),
    .checked_o     (n_checked),
    .fail_count_o  (n_fail)
  );

  // clock
  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  // watchdog
  initial begin
    while (n_cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      n_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  // receiver: random stalls, and one long hold-off when the pressure phase starts
  initial begin
    forever begin
      @(posedge clk_i);
      if (cur_phase == PH_PRESSURE && !stretch_done) begin
        stretch_done = 1'b1;
        repeat (STALL_LEN) begin
          m_tready <= 1'b0;
          @(posedge clk_i);
        end
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // offer one word, with random idle cycles before it
  task automatic send_word(input logic raw, input logic [NOW_BITS-1:0] now_ms);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_BITS'({now_ms, raw});
    do begin
      @(posedge clk_i);
    end while (!s_tready);
    n_sent++;
  endtask

  // let every expected level arrive, then some cycles for the pipeline
  task automatic drain_words();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // write both registers while idle
  task automatic set_config(input logic [MODE_BITS-1:0] mode,
                            input logic [HOLD_BITS-1:0] hold);
    drain_words();
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_EDGE_MODE;
    cfg_data <= CFG_DATA_BITS'(mode);
    @(posedge clk_i);
    cfg_idx  <= REG_HOLD_TIME;
    cfg_data <= CFG_DATA_BITS'(hold);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // main stimulus
  initial begin
    logic [31:0]          t_ms;
    logic [HOLD_BITS-1:0] hold_sel;
    logic [31:0]          step_max;
    logic                 raw_lvl;
    int                   n_bounce;
    int                   n_steady;
    int                   target;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first word adopts its sample, then zero hold passes at once, across a wrap
    send_word(1'b1, 32'hFFFF_FFF0);
    send_word(1'b0, 32'hFFFF_FFF5);
    send_word(1'b1, 32'h0000_0002);
    send_word(1'b0, 32'h0000_0000);

    // both edges held for 10 ms, with a bounce train
    set_config(MODE_BOTH, 32'd10);
    send_word(1'b1, 32'd100);
    send_word(1'b1, 32'd105);
    send_word(1'b1, 32'd110);
    send_word(1'b0, 32'd111);
    send_word(1'b1, 32'd112);
    send_word(1'b0, 32'd113);
    send_word(1'b0, 32'd122);
    send_word(1'b0, 32'd123);

    // rising held, falling passes
    set_config(MODE_RISE, 32'd10);
    send_word(1'b1, 32'd200);
    send_word(1'b1, 32'd210);
    send_word(1'b0, 32'd211);

    // falling held, rising passes
    set_config(MODE_FALL, 32'd10);
    send_word(1'b1, 32'd300);
    send_word(1'b0, 32'd301);
    send_word(1'b0, 32'd311);

    // unused mode value behaves as falling only
    set_config(MODE_UNUSED, 32'd10);
    send_word(1'b1, 32'd400);
    send_word(1'b0, 32'd401);
    send_word(1'b0, 32'd410);
    send_word(1'b0, 32'd411);

    // full scale hold met only by a full wrap of the time
    set_config(MODE_BOTH, 32'hFFFF_FFFF);
    send_word(1'b1, 32'd1000);
    send_word(1'b1, 32'd999);

    // steady time measured across the wrap
    set_config(MODE_BOTH, 32'd10);
    send_word(1'b0, 32'hFFFF_FFFC);
    send_word(1'b0, 32'h0000_0006);

    // random part: four idling phases, each with several settings
    t_ms    = $urandom;
    raw_lvl = 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      case (idle_phase_e'(ph))
        PH_TX_IDLE:   begin tx_idle_pct = 60; rx_stall_pct <= 0;  end
        PH_RX_STALL:  begin tx_idle_pct = 0;  rx_stall_pct <= 60; end
        PH_BOTH_IDLE: begin tx_idle_pct = 6;  rx_stall_pct <= 6;  end
        default:      begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
      endcase
      cur_phase <= idle_phase_e'(ph);
      for (int seg = 0; seg < 4; seg++) begin
        case ($urandom_range(0, 9))
          0:       hold_sel = '0;
          1:       hold_sel = '1;
          2:       hold_sel = $urandom;
          3, 4:    hold_sel = $urandom_range(1, 1000);
          default: hold_sel = $urandom_range(1, 20);
        endcase
        set_config(MODE_BITS'($urandom_range(0, 3)), hold_sel);
        step_max = (hold_sel < 32'd4000) ? hold_sel / 2 + 1 : 32'd2000;
        target   = n_sent + 50;
        while (n_sent < target) begin
          case ($urandom_range(0, 9))
            0: begin
              // noise: any level at any time
              t_ms    = $urandom;
              raw_lvl = 1'($urandom_range(0, 1));
              send_word(raw_lvl, t_ms);
            end
            1: begin
              // land right at the hold threshold
              t_ms = t_ms + hold_sel + $urandom_range(0, 2) - 1;
              send_word(raw_lvl, t_ms);
            end
            default: begin
              // bounce train then a steady stretch
              n_bounce = $urandom_range(0, 4);
              n_steady = $urandom_range(1, 6);
              repeat (n_bounce) begin
                raw_lvl = ~raw_lvl;
                t_ms    = t_ms + $urandom_range(0, 3);
                send_word(raw_lvl, t_ms);
              end
              repeat (n_steady) begin
                t_ms = t_ms + $urandom_range(0, step_max);
                send_word(raw_lvl, t_ms);
              end
            end
          endcase
        end
      end
    end

    // pressure: sender keeps offering while the receiver holds off
    set_config(MODE_BITS'($urandom_range(0, 3)), HOLD_BITS'($urandom_range(0, 20)));
    tx_idle_pct = 0;
    rx_stall_pct <= 0;
    cur_phase    <= PH_PRESSURE;
    repeat (40) begin
      t_ms = t_ms + $urandom_range(0, 5);
      send_word(1'($urandom_range(0, 1)), t_ms);
    end

    // wait for the tail and give the verdict
    drain_words();
    repeat (8) @(posedge clk_i);
    $display("run sent %0d words and checked %0d levels over all edge modes and hold times",
             n_sent, n_checked);
    $display("including first word, time wrap, bounce trains, idling phases and a long stall");
    if (n_fail == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/esd_pkg.sv
design/esd_cfg_regs.sv
design/esd_step.sv
design/edge_selective_debouncer_core.sv
bench/esd_level_checker.sv
bench/edge_selective_debouncer_core_tb.sv
